/* hw/rtl/i2c_target_byte_buffer_engine_macros.svh */
// assertion helpers used by the byte buffer engine rtl
`ifndef I2C_TARGET_BYTE_BUFFER_ENGINE_MACROS_SVH
`define I2C_TARGET_BYTE_BUFFER_ENGINE_MACROS_SVH

`ifndef SYNTH
`define TBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define TBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define TBE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TBE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/tbe_pkg.sv */
`timescale 1ns / 1ps
package tbe_pkg;

	localparam int FIFO_DEPTH = 128;
	localparam int IDX_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_EVENT = 2'd2,
		OP_DATA  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_ACK  = 2'd1,
		ACT_NACK = 2'd2,
		ACT_DONE = 2'd3
	} action_t;

	typedef struct packed {
		logic put;
		logic get;
	} fifo_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* hw/rtl/tbe_ram.sv */
`timescale 1ns / 1ps
module tbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/tbe_fifo.sv */
`timescale 1ns / 1ps
module tbe_fifo import tbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fifo_req_t         req,
	input  logic [BYTE_W-1:0] wdata,
	output fifo_stat_t        stat,
	output logic [BYTE_W-1:0] rdata
);

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] tail;
	logic             do_put;
	logic             do_get;

	assign stat.full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_put     = req.put && !stat.full;
	assign do_get     = req.get && !stat.empty;
	// tail wraps by dropping the upper count bit
	assign tail       = head_q + cnt_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_get) begin
				head_q <= head_q + IDX_W'(1);
			end
			if (do_put) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_get) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	tbe_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (do_put),
		.waddr(tail),
		.wdata(wdata),
		.re   (do_get),
		.raddr(head_q),
		.rdata(rdata)
	);

endmodule

/* hw/rtl/i2c_target_byte_buffer_engine.sv */
`timescale 1ns / 1ps
`include "i2c_target_byte_buffer_engine_macros.svh"
// I2C target byte buffer. One host or bus event is taken per start beat and
// its result appears on status, data_out and bus_action for exactly one
// cycle with done high, in the cycle after the start beat. busy stays low, so
// a new beat can be started every cycle: each event makes at most one access
// to one of the two 128-byte FIFO memories, and the memory's registered
// read port places the result in the following cycle. done cannot be held
// off, so the receiver must sample the result in the cycle done is high.
module i2c_target_byte_buffer_engine import tbe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic              bus_read,
	input  logic              is_address,
	input  logic [BYTE_W-1:0] data_in,
	output logic              done,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] data_out,
	output logic [1:0]        bus_action
);

	logic       accept;
	op_t        op_in;
	fifo_req_t  tx_req;
	fifo_req_t  rx_req;
	fifo_stat_t tx_stat;
	fifo_stat_t rx_stat;
	logic [BYTE_W-1:0] tx_rdata;
	logic [BYTE_W-1:0] rx_rdata;

	status_t status_d;
	action_t action_d;
	logic    nack_d;
	logic    rd_d;
	logic    rd_rx_d;

	logic    nack_q;
	logic    valid_s1;
	status_t status_s1;
	action_t action_s1;
	logic    rd_s1;
	logic    rd_rx_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign op_in  = op_t'(op);

	always_comb begin
		tx_req   = '0;
		rx_req   = '0;
		status_d = ST_OK;
		action_d = ACT_NONE;
		nack_d   = nack_q;
		rd_d     = 1'b0;
		rd_rx_d  = 1'b0;
		unique case (op_in)
			OP_PUSH: begin
				tx_req.put = accept;
				if (tx_stat.full) begin
					status_d = ST_FULL;
				end
			end
			OP_POP: begin
				rx_req.get = accept;
				rd_rx_d    = 1'b1;
				if (rx_stat.empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_d = 1'b1;
				end
			end
			OP_EVENT: begin
				// address match re-arms ack, stop sets nack
				nack_d   = !is_address;
				action_d = is_address ? ACT_ACK : ACT_DONE;
			end
			OP_DATA: begin
				if (bus_read) begin
					tx_req.get = accept;
					if (tx_stat.empty) begin
						status_d = ST_EMPTY;
						nack_d   = 1'b1;
					end else begin
						rd_d = 1'b1;
					end
				end else begin
					rx_req.put = accept;
					if (rx_stat.full) begin
						status_d = ST_FULL;
						nack_d   = 1'b1;
					end
				end
				action_d = nack_d ? ACT_NACK : ACT_ACK;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nack_q   <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				nack_q <= nack_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			action_s1 <= action_d;
			rd_s1     <= rd_d;
			rd_rx_s1  <= rd_rx_d;
		end
	end

	tbe_fifo u_tx_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (tx_req),
		.wdata (data_in),
		.stat  (tx_stat),
		.rdata (tx_rdata)
	);

	tbe_fifo u_rx_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (rx_req),
		.wdata (data_in),
		.stat  (rx_stat),
		.rdata (rx_rdata)
	);

	assign done       = valid_s1;
	assign status     = status_s1;
	assign bus_action = action_s1;
	assign data_out   = !rd_s1 ? '0 : (rd_rx_s1 ? rx_rdata : tx_rdata);

	`TBE_ASSERT_NEXT(a_beat_done, clk, arst_n, accept, done)
	`TBE_ASSERT_SAME(a_fail_no_data, clk, arst_n, done && status != ST_OK, data_out == '0)
	`TBE_ASSERT_NEXT(a_rx_full_nack, clk, arst_n, accept && op_in == OP_DATA && !bus_read && rx_stat.full, status == ST_FULL && bus_action == ACT_NACK && nack_q)
	`TBE_ASSERT_NEXT(a_stop_done, clk, arst_n, accept && op_in == OP_EVENT && !is_address, nack_q && bus_action == ACT_DONE)

endmodule

/* bench/tb_i2c_target_byte_buffer_engine.sv */
`timescale 1ns / 1ps
module tb_i2c_target_byte_buffer_engine;
	import tbe_pkg::*;

	localparam int ITEM_TARGET = 2000;
	localparam int IDLE_LIMIT  = 200;
	localparam int DRAIN_WAIT  = 4;

	typedef enum int {
		FILL_TX,
		DRAIN_TX,
		FILL_RX,
		DRAIN_RX,
		TRANSACTIONS,
		NOISE
	} traffic_mode_t;

	// tracks both fifos and the sticky nack, and holds the replies still owed
	class reply_tracker;
		typedef struct packed {
			status_t           st;
			logic [BYTE_W-1:0] byte_val;
			action_t           act;
		} reply_t;

		logic [BYTE_W-1:0] tx_mem[FIFO_DEPTH];
		logic [BYTE_W-1:0] rx_mem[FIFO_DEPTH];
		int                tx_head, tx_count, rx_head, rx_count;
		bit                nack_held;
		reply_t            expected_replies[$];
		int                errors, n_items, n_full, n_empty, n_nack, n_done;

		function new();
			tx_head   = 0;
			tx_count  = 0;
			rx_head   = 0;
			rx_count  = 0;
			nack_held = 0;
			errors    = 0;
			n_items   = 0;
			n_full    = 0;
			n_empty   = 0;
			n_nack    = 0;
			n_done    = 0;
		endfunction

		function void take_event(op_t o, logic rd, logic addr, logic [BYTE_W-1:0] d);
			reply_t r;
			r.st       = ST_OK;
			r.byte_val = '0;
			r.act      = ACT_NONE;
			case (o)
				OP_PUSH: begin
					if (tx_count >= FIFO_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						tx_mem[(tx_head + tx_count) & (FIFO_DEPTH - 1)] = d;
						tx_count++;
					end
				end
				OP_POP: begin
					if (rx_count == 0) begin
						r.st = ST_EMPTY;
					end else begin
						r.byte_val = rx_mem[rx_head];
						rx_head    = (rx_head + 1) & (FIFO_DEPTH - 1);
						rx_count--;
					end
				end
				OP_EVENT: begin
					if (addr) begin
						nack_held = 0;
						r.act     = ACT_ACK;
					end else begin
						// stop leaves the ack action at nack
						nack_held = 1;
						r.act     = ACT_DONE;
					end
				end
				default: begin
					if (rd) begin
						if (tx_count == 0) begin
							r.st      = ST_EMPTY;
							nack_held = 1;
						end else begin
							r.byte_val = tx_mem[tx_head];
							tx_head    = (tx_head + 1) & (FIFO_DEPTH - 1);
							tx_count--;
						end
					end else begin
						if (rx_count >= FIFO_DEPTH) begin
							r.st      = ST_FULL;
							nack_held = 1;
						end else begin
							rx_mem[(rx_head + rx_count) & (FIFO_DEPTH - 1)] = d;
							rx_count++;
						end
					end
					r.act = nack_held ? ACT_NACK : ACT_ACK;
				end
			endcase
			n_items++;
			if (r.st == ST_FULL) n_full++;
			if (r.st == ST_EMPTY) n_empty++;
			if (r.act == ACT_NACK) n_nack++;
			if (r.act == ACT_DONE) n_done++;
			expected_replies.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic [BYTE_W-1:0] b, logic [1:0] act);
			reply_t exp_r;
			if (expected_replies.size() == 0) begin
				$error("reply beat with nothing outstanding: status %0d data_out %0d bus_action %0d",
					st, b, act);
				errors++;
				return;
			end
			exp_r = expected_replies.pop_front();
			if (st !== exp_r.st) begin
				$error("status: expected %0d, got %0d", exp_r.st, st);
				errors++;
			end
			if (b !== exp_r.byte_val) begin
				$error("data_out: expected %0d, got %0d", exp_r.byte_val, b);
				errors++;
			end
			if (act !== exp_r.act) begin
				$error("bus_action: expected %0d, got %0d", exp_r.act, act);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_replies.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        op;
	logic              bus_read;
	logic              is_address;
	logic [BYTE_W-1:0] data_in;
	logic              done;
	logic [1:0]        status;
	logic [BYTE_W-1:0] data_out;
	logic [1:0]        bus_action;

	reply_tracker tracker = new();
	int           items_sent = 0;
	int           burst_left = 0;
	int           idle_cycles = 0;

	i2c_target_byte_buffer_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.bus_read   (bus_read),
		.is_address (is_address),
		.data_in    (data_in),
		.done       (done),
		.status     (status),
		.data_out   (data_out),
		.bus_action (bus_action)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// beat monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) tracker.check_reply(status, data_out, bus_action);
			if (start && !busy) tracker.take_event(op_t'(op), bus_read, is_address, data_in);
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_item(input op_t o, input logic rd, input logic addr,
			input logic [BYTE_W-1:0] d);
		int gap;
		start      <= 1'b1;
		op         <= o;
		bus_read   <= rd;
		is_address <= addr;
		data_in    <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 40);
		end
	endtask

	task automatic random_item(input traffic_mode_t mode);
		int   p;
		op_t  o;
		logic rd;
		p  = $urandom_range(0, 99);
		o  = op_t'($urandom_range(0, 3));
		rd = 1'($urandom_range(0, 1));
		case (mode)
			FILL_TX: if (p < 80) o = OP_PUSH;
			DRAIN_TX: if (p < 80) begin
				o  = OP_DATA;
				rd = 1'b1;
			end
			FILL_RX: if (p < 80) begin
				o  = OP_DATA;
				rd = 1'b0;
			end
			DRAIN_RX: if (p < 80) o = OP_POP;
			default: ;
		endcase
		send_item(o, rd, 1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
	endtask

	// address, a run of data beats in one direction with some host traffic, then stop
	task automatic run_transaction();
		int   n;
		logic rd;
		rd = 1'($urandom_range(0, 1));
		n  = $urandom_range(1, 10);
		send_item(OP_EVENT, 1'($urandom_range(0, 1)), 1'b1, BYTE_W'($urandom_range(0, 255)));
		repeat (n) begin
			if ($urandom_range(0, 99) < 20)
				send_item(rd ? OP_PUSH : OP_POP, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
			send_item(OP_DATA, rd, 1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
		end
		send_item(OP_EVENT, 1'($urandom_range(0, 1)), 1'b0, BYTE_W'($urandom_range(0, 255)));
	endtask

	initial begin
		traffic_mode_t mode;
		int            phase_len;
		start      = 1'b0;
		op         = OP_PUSH;
		bus_read   = 1'b0;
		is_address = 1'b0;
		data_in    = '0;
		arst_n     = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pops, sticky nack, address clear, stop, byte extremes
		send_item(OP_POP, 1'b1, 1'b1, 8'hFF);
		send_item(OP_DATA, 1'b1, 1'b0, 8'h00);
		send_item(OP_DATA, 1'b0, 1'b1, 8'h5A);
		send_item(OP_EVENT, 1'b0, 1'b1, 8'h00);
		send_item(OP_DATA, 1'b0, 1'b0, 8'h00);
		send_item(OP_DATA, 1'b0, 1'b0, 8'hFF);
		send_item(OP_PUSH, 1'b0, 1'b0, 8'h00);
		send_item(OP_PUSH, 1'b1, 1'b1, 8'hFF);
		send_item(OP_PUSH, 1'b0, 1'b0, 8'hA5);
		send_item(OP_DATA, 1'b1, 1'b0, 8'h3C);
		send_item(OP_DATA, 1'b1, 1'b1, 8'hC3);
		send_item(OP_EVENT, 1'b1, 1'b0, 8'hFF);
		send_item(OP_DATA, 1'b1, 1'b0, 8'h00);
		send_item(OP_POP, 1'b0, 1'b0, 8'h00);
		send_item(OP_POP, 1'b0, 1'b0, 8'h00);
		send_item(OP_POP, 1'b0, 1'b0, 8'h00);
		send_item(OP_POP, 1'b1, 1'b1, 8'hFF);
		send_item(OP_EVENT, 1'b1, 1'b1, 8'hFF);
		send_item(OP_DATA, 1'b1, 1'b1, 8'hFF);

		// random phases, biased so both fifos reach full and empty
		while (items_sent < ITEM_TARGET) begin
			mode = traffic_mode_t'($urandom_range(0, 5));
			if (mode == TRANSACTIONS) begin
				repeat ($urandom_range(3, 10)) run_transaction();
			end else begin
				phase_len = $urandom_range(20, 250);
				repeat (phase_len) random_item(mode);
			end
		end
		start <= 1'b0;

		while (tracker.outstanding() > 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d beats: %0d full, %0d empty, %0d nack, %0d stop replies",
			tracker.n_items, tracker.n_full, tracker.n_empty, tracker.n_nack, tracker.n_done);
		if (tracker.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tbe_pkg.sv
hw/rtl/tbe_ram.sv
hw/rtl/tbe_fifo.sv
hw/rtl/i2c_target_byte_buffer_engine.sv
bench/tb_i2c_target_byte_buffer_engine.sv
